// ===== hdl/spq_pkg.sv =====
// shared types, codes and defaults for the stable priority queue
package spq_pkg;

	// default number of stored entries
	localparam int unsigned DEPTH_DEFAULT = 16;

	// operation codes
	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_REMOVE = 1'b1;

	// status codes
	localparam logic [1:0] STATUS_DONE  = 2'd0;
	localparam logic [1:0] STATUS_FULL  = 2'd1;
	localparam logic [1:0] STATUS_EMPTY = 2'd2;

	// request transaction
	typedef struct packed {
		logic               operation;
		logic signed [31:0] item_value;
		logic        [15:0] priority_req;
	} req_t;

	// response transaction
	typedef struct packed {
		logic        [1:0]  status;
		logic signed [31:0] removed_value;
		logic        [4:0]  entry_count;
	} rsp_t;

	// one stored entry
	typedef struct packed {
		logic        [15:0] pri;
		logic signed [31:0] val;
	} entry_t;

endpackage

// ===== hdl/stable_priority_queue_unit.sv =====
// sorted priority queue, ties leave in arrival order; circular entry store
// flow: a refused op goes straight to the response, a remove pops the head, an
//   insert shifts up entries with a larger priority number and stores its own
// throughput: one transaction at a time; a single priority comparator walks
//   the store from the tail, moving one entry per cycle through the memory port
// reset: count, head and control clear at once; the store itself is not cleared
module stable_priority_queue_unit #(
	parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output spq_pkg::rsp_t rsp
);
	import spq_pkg::*;

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned SW = AW + 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_LOOK = 5'b00010,
		S_CMP  = 5'b00100,
		S_POP  = 5'b01000,
		S_RESP = 5'b10000
	} state_t;

	state_t             state_q;
	logic [CW-1:0]      count_q;
	logic [AW-1:0]      head_q;
	logic [CW-1:0]      idx_q;
	logic [15:0]        pri_q;
	logic signed [31:0] val_q;
	logic [1:0]         pend_status_q;
	logic signed [31:0] pend_value_q;
	logic               rsp_valid_q;
	rsp_t               rsp_q;

	logic               mem_we;
	logic [AW-1:0]      mem_waddr;
	entry_t             mem_wdata;
	logic [AW-1:0]      mem_raddr;
	entry_t             mem_rdata;
	logic [CW-1:0]      rd_off;
	logic               stop;
	logic               accept;
	logic               out_free;
	logic [CW+4:0]      count_ext;

	// circular address: base plus logical offset, one compare and subtract
	function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] base,
			input logic [CW-1:0] off);
		logic [SW-1:0] sum;
		sum = SW'(base) + SW'(off);
		if (sum >= SW'(DEPTH)) begin
			sum = sum - SW'(DEPTH);
		end
		return sum[AW-1:0];
	endfunction

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign stop      = (mem_rdata.pri <= pri_q);
	assign count_ext = {5'b0, count_q};

	// memory port steering
	always_comb begin
		rd_off = '0;
		if (state_q == S_LOOK && idx_q != '0) begin
			rd_off = idx_q - CW'(1);
		end else if (state_q == S_CMP && idx_q >= CW'(2)) begin
			rd_off = idx_q - CW'(2);
		end
		mem_raddr = wrap_add(head_q, rd_off);
		mem_waddr = wrap_add(head_q, idx_q);
		mem_we    = 1'b0;
		mem_wdata = '{pri: pri_q, val: val_q};
		unique case (state_q)
			S_LOOK: begin
				mem_we = (idx_q == '0);
			end
			S_CMP: begin
				mem_we = 1'b1;
				if (!stop) begin
					mem_wdata = mem_rdata;
				end
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	spq_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (mem_we),
		.wr_addr (mem_waddr),
		.wr_data (mem_wdata),
		.rd_addr (mem_raddr),
		.rd_data (mem_rdata)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			head_q  <= '0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.operation == OP_INSERT) begin
							if (count_q == CW'(DEPTH)) begin
								state_q <= S_RESP;
							end else begin
								idx_q   <= count_q;
								state_q <= S_LOOK;
							end
						end else if (count_q == '0) begin
							state_q <= S_RESP;
						end else begin
							state_q <= S_POP;
						end
					end
				end
				S_LOOK: begin
					if (idx_q == '0) begin
						count_q <= count_q + CW'(1);
						state_q <= S_RESP;
					end else begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					if (stop) begin
						count_q <= count_q + CW'(1);
						state_q <= S_RESP;
					end else begin
						idx_q <= idx_q - CW'(1);
						if (idx_q < CW'(2)) begin
							state_q <= S_LOOK;
						end
					end
				end
				S_POP: begin
					head_q  <= wrap_add(head_q, CW'(1));
					count_q <= count_q - CW'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request payload and pending result
	always_ff @(posedge clk) begin
		if (accept) begin
			pri_q        <= req.priority_req;
			val_q        <= req.item_value;
			pend_value_q <= '0;
			if (req.operation == OP_INSERT) begin
				pend_status_q <= (count_q == CW'(DEPTH)) ? STATUS_FULL : STATUS_DONE;
			end else begin
				pend_status_q <= (count_q == '0) ? STATUS_EMPTY : STATUS_DONE;
			end
		end
		if (state_q == S_POP) begin
			pend_value_q <= mem_rdata.val;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_RESP && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_RESP && out_free) begin
			rsp_q.status        <= pend_status_q;
			rsp_q.removed_value <= pend_value_q;
			rsp_q.entry_count   <= count_ext[4:0];
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// checks
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_full_refuse: assert property (@(posedge clk) disable iff (!arst_n)
		accept && req.operation == OP_INSERT && count_q == CW'(DEPTH)
		|=> state_q == S_RESP && $stable(count_q) && $stable(head_q))
		else $error("insert into full store not refused");

	a_cmp_index: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CMP |-> idx_q != '0)
		else $error("compare step with no entry below");

endmodule

// ===== hdl/spq_mem.sv =====
// entry storage: one write port, one registered read port
module spq_mem #(
	parameter int unsigned DEPTH = spq_pkg::DEPTH_DEFAULT,
	parameter int unsigned AW    = $clog2(DEPTH)
) (
	input  logic            clk,
	input  logic            wr_en,
	input  logic [AW-1:0]   wr_addr,
	input  spq_pkg::entry_t wr_data,
	input  logic [AW-1:0]   rd_addr,
	output spq_pkg::entry_t rd_data
);
	import spq_pkg::*;

	entry_t mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule
